/* hdl/glyph_rectangle_clip_defines.svh */
`ifndef GLYPH_RECTANGLE_CLIP_DEFINES_SVH
`define GLYPH_RECTANGLE_CLIP_DEFINES_SVH

// checked only out of reset
`define GRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define GRC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/grc_pkg.sv */
`timescale 1ns / 1ps
package grc_pkg;

  localparam int FRAME_W     = 15;
  localparam int FRAME_MAX   = 16384;
  localparam int OUT_POS_W   = 14;
  localparam int OUT_LEN_W   = 15;
  localparam int POS_MAX     = 16383;
  localparam int LEN_MAX     = 16384;
  localparam logic [FRAME_W-1:0] FRAME_W_RST = 15'd640;
  localparam logic [FRAME_W-1:0] FRAME_H_RST = 15'd480;

  typedef logic [FRAME_W-1:0] frame_t;

  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_index_t;

  // zero reads as one, anything above the maximum as the maximum
  function automatic frame_t frame_dim(input frame_t r);
    frame_t d;
    if (r == '0) d = frame_t'(1);
    else if (r > frame_t'(FRAME_MAX)) d = frame_t'(FRAME_MAX);
    else d = r;
    return d;
  endfunction

endpackage

/* hdl/grc_if.sv */
`timescale 1ns / 1ps
interface grc_in_if #(parameter int COORD_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] dest_x;
  logic signed [COORD_BITS-1:0] dest_y;
  logic signed [COORD_BITS-1:0] dest_width;
  logic signed [COORD_BITS-1:0] dest_height;
  logic signed [COORD_BITS-1:0] tex_u;
  logic signed [COORD_BITS-1:0] tex_v;
  logic signed [COORD_BITS-1:0] tex_width;
  logic signed [COORD_BITS-1:0] tex_height;
  logic                         hidden;

  modport source (output valid, dest_x, dest_y, dest_width, dest_height, tex_u, tex_v,
                  tex_width, tex_height, hidden, input ready);
  modport sink   (input valid, dest_x, dest_y, dest_width, dest_height, tex_u, tex_v,
                  tex_width, tex_height, hidden, output ready);
endinterface

interface grc_out_if #(parameter int COORD_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic                         visible;
  logic [13:0]                  out_x;
  logic [13:0]                  out_y;
  logic [14:0]                  out_width;
  logic [14:0]                  out_height;
  logic signed [COORD_BITS-1:0] out_u;
  logic signed [COORD_BITS-1:0] out_v;
  logic signed [COORD_BITS-1:0] out_tex_width;
  logic signed [COORD_BITS-1:0] out_tex_height;

  modport source (output valid, visible, out_x, out_y, out_width, out_height, out_u, out_v,
                  out_tex_width, out_tex_height, input ready);
  modport sink   (input valid, visible, out_x, out_y, out_width, out_height, out_u, out_v,
                  out_tex_width, out_tex_height, output ready);
endinterface

/* hdl/grc_div.sv */
`timescale 1ns / 1ps
module grc_div #(
  parameter int N      = 16,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  logic signed [2*N-1:0] in_prod,
  input  logic [N-1:0]        in_den,
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_vld,
  output logic signed [N:0]   out_quo,
  output logic [SIDE_W-1:0]   out_side
);

  // stage 0 takes the magnitude, stages 1..N each settle one quotient bit
  logic              vld_r  [0:N];
  logic              neg_r  [0:N];
  logic [N-1:0]      rem_r  [0:N];
  logic [N-1:0]      low_r  [0:N];
  logic [N-1:0]      quo_r  [0:N];
  logic [N-1:0]      den_r  [0:N];
  logic [SIDE_W-1:0] side_r [0:N];

  logic [2*N-1:0] mag;
  assign mag = in_prod[2*N-1] ? (2*N)'(-in_prod) : (2*N)'(in_prod);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r[0]  <= in_prod[2*N-1];
      rem_r[0]  <= mag[2*N-1:N];
      low_r[0]  <= mag[N-1:0];
      quo_r[0]  <= '0;
      den_r[0]  <= in_den;
      side_r[0] <= in_side;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [N:0]   trial;
    logic         ge;
    logic [N:0]   diff;
    logic [N-1:0] rem_nxt;

    assign trial   = {rem_r[k], low_r[k][N-1]};
    assign ge      = trial >= {1'b0, den_r[k]};
    assign diff    = trial - {1'b0, den_r[k]};
    assign rem_nxt = ge ? diff[N-1:0] : trial[N-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        neg_r[k+1]  <= neg_r[k];
        rem_r[k+1]  <= rem_nxt;
        low_r[k+1]  <= low_r[k] << 1;
        quo_r[k+1]  <= {quo_r[k][N-2:0], ge};
        den_r[k+1]  <= den_r[k];
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign out_vld  = vld_r[N];
  assign out_side = side_r[N];
  assign out_quo  = neg_r[N] ? -$signed({1'b0, quo_r[N]}) : $signed({1'b0, quo_r[N]});

endmodule

/* hdl/grc_axis.sv */
`timescale 1ns / 1ps
module grc_axis #(
  parameter int C       = 16,
  parameter int OSIDE_W = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic signed [C-1:0]  in_pos,
  input  logic signed [C-1:0]  in_len,
  input  logic signed [C-1:0]  in_t0,
  input  logic signed [C-1:0]  in_tl,
  input  grc_pkg::frame_t      in_fd,
  input  logic [OSIDE_W-1:0]   in_side,
  output logic                 out_vld,
  output logic signed [C-1:0]  out_pos,
  output logic signed [C-1:0]  out_len,
  output logic signed [C:0]    out_t0,
  output logic signed [C:0]    out_tl,
  output logic [OSIDE_W-1:0]   out_side
);
  import grc_pkg::*;

  localparam int EW = ((C > FRAME_W) ? C : FRAME_W) + 2;

  typedef struct packed {
    logic signed [C-1:0] pos;
    logic signed [C-1:0] len;
    logic signed [C-1:0] t0;
    logic signed [C-1:0] tl;
    frame_t              fd;
    logic                cut;
    logic [OSIDE_W-1:0]  side;
  } side1_t;

  typedef struct packed {
    logic signed [C-1:0] pos;
    logic signed [C-1:0] len;
    logic signed [C:0]   t0;
    logic signed [C:0]   tl;
    logic [OSIDE_W-1:0]  side;
  } side2_t;

  // stage a: left or top cut product
  logic                  a_vld_r;
  logic signed [2*C-1:0] a_prod_r;
  logic [C-1:0]          a_den_r;
  side1_t                a_side_r;
  logic                  cut1;
  logic signed [2*C-1:0] prod1;
  assign cut1  = in_pos[C-1];
  assign prod1 = in_pos * in_tl;

  always_ff @(posedge clk) begin
    if (!rst_n) a_vld_r <= 1'b0;
    else if (en) a_vld_r <= in_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_prod_r <= cut1 ? prod1 : '0;
      a_den_r  <= in_len;
      a_side_r <= '{pos: in_pos, len: in_len, t0: in_t0, tl: in_tl, fd: in_fd,
                    cut: cut1, side: in_side};
    end
  end

  logic                d1_vld;
  logic signed [C:0]   d1_quo;
  logic [$bits(side1_t)-1:0] d1_side_raw;
  side1_t              d1_side;

  grc_div #(.N(C), .SIDE_W($bits(side1_t))) u_div1 (
    .clk, .rst_n, .en,
    .in_vld(a_vld_r), .in_prod(a_prod_r), .in_den(a_den_r), .in_side(a_side_r),
    .out_vld(d1_vld), .out_quo(d1_quo), .out_side(d1_side_raw)
  );
  assign d1_side = side1_t'(d1_side_raw);

  // stage b: apply the near cut
  logic                b_vld_r;
  logic signed [C-1:0] b_pos_r;
  logic signed [C-1:0] b_len_r;
  logic signed [C:0]   b_t0_r;
  logic signed [C:0]   b_tl_r;
  frame_t              b_fd_r;
  logic [OSIDE_W-1:0]  b_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b_vld_r <= 1'b0;
    else if (en) b_vld_r <= d1_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_fd_r   <= d1_side.fd;
      b_side_r <= d1_side.side;
      if (d1_side.cut) begin
        b_pos_r <= '0;
        b_len_r <= d1_side.len + d1_side.pos;
        b_t0_r  <= (C+1)'(d1_side.t0) - d1_quo;
        b_tl_r  <= (C+1)'(d1_side.tl) + d1_quo;
      end else begin
        b_pos_r <= d1_side.pos;
        b_len_r <= d1_side.len;
        b_t0_r  <= (C+1)'(d1_side.t0);
        b_tl_r  <= (C+1)'(d1_side.tl);
      end
    end
  end

  // stage c: far cut product, overhang is negative when the far edge sticks out
  logic signed [EW-1:0] over;
  logic                 cut2;
  assign over = $signed(EW'({1'b0, b_fd_r})) - EW'(b_pos_r) - EW'(b_len_r);
  assign cut2 = over[EW-1];

  logic                  c_vld_r;
  logic signed [2*C-1:0] c_prod_r;
  logic [C-1:0]          c_den_r;
  side2_t                c_side_r;
  logic signed [C-1:0]   over_c;
  logic signed [C-1:0]   tl_c;
  logic signed [2*C-1:0] prod2;
  assign over_c = over[C-1:0];
  assign tl_c   = b_tl_r[C-1:0];
  assign prod2  = over_c * tl_c;

  always_ff @(posedge clk) begin
    if (!rst_n) c_vld_r <= 1'b0;
    else if (en) c_vld_r <= b_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_prod_r <= cut2 ? prod2 : '0;
      c_den_r  <= b_len_r;
      c_side_r <= '{pos: b_pos_r, len: cut2 ? b_len_r + over_c : b_len_r,
                    t0: b_t0_r, tl: b_tl_r, side: b_side_r};
    end
  end

  logic                d2_vld;
  logic signed [C:0]   d2_quo;
  logic [$bits(side2_t)-1:0] d2_side_raw;
  side2_t              d2_side;

  grc_div #(.N(C), .SIDE_W($bits(side2_t))) u_div2 (
    .clk, .rst_n, .en,
    .in_vld(c_vld_r), .in_prod(c_prod_r), .in_den(c_den_r), .in_side(c_side_r),
    .out_vld(d2_vld), .out_quo(d2_quo), .out_side(d2_side_raw)
  );
  assign d2_side = side2_t'(d2_side_raw);

  // stage d: far cut on the texel extent
  logic                d_vld_r;
  logic signed [C-1:0] d_pos_r;
  logic signed [C-1:0] d_len_r;
  logic signed [C:0]   d_t0_r;
  logic signed [C:0]   d_tl_r;
  logic [OSIDE_W-1:0]  d_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) d_vld_r <= 1'b0;
    else if (en) d_vld_r <= d2_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_pos_r  <= d2_side.pos;
      d_len_r  <= d2_side.len;
      d_t0_r   <= d2_side.t0;
      d_tl_r   <= d2_side.tl + d2_quo;
      d_side_r <= d2_side.side;
    end
  end

  assign out_vld  = d_vld_r;
  assign out_pos  = d_pos_r;
  assign out_len  = d_len_r;
  assign out_t0   = d_t0_r;
  assign out_tl   = d_tl_r;
  assign out_side = d_side_r;

endmodule

/* hdl/glyph_rectangle_clip.sv */
`timescale 1ns / 1ps
// glyph_rectangle_clip: clips a textured destination rectangle to the frame
//
// in_chan carries one destination rectangle, its texel rectangle and a hidden
// flag; out_chan returns one result per item with a visible flag and the
// clipped rectangles. valid/ready on both; a transfer happens when both are high.
// cfg_we with cfg_index writes frame width or height; write only while idle.
//
// one item per cycle sustained while the receiver takes results. the pipeline
// holds two restoring dividers per axis (one quotient bit a stage), the
// near-edge cut feeding the far-edge cut, plus input, reject, multiply and
// output stages.
//
// a synchronous low rst_n empties the pipeline and loads 640 x 480.
// every stage moves on together: when the output register holds a result
// that the receiver does not take, the whole pipeline and in_chan.ready hold.
`include "glyph_rectangle_clip_defines.svh"
module glyph_rectangle_clip #(
  parameter int COORD_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  grc_in_if.sink               in_chan,
  grc_out_if.source            out_chan,
  input  logic                 cfg_we,
  input  grc_pkg::cfg_index_t  cfg_index,
  input  grc_pkg::frame_t      cfg_wdata
);
  import grc_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int EW = ((C > FRAME_W) ? C : FRAME_W) + 2;

  logic en;

  // frame registers
  frame_t frame_w_r;
  frame_t frame_h_r;
  frame_t fw;
  frame_t fh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_w_r <= FRAME_W_RST;
      frame_h_r <= FRAME_H_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_w_r <= cfg_wdata;
        CFG_FRAME_HEIGHT: frame_h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign fw = frame_dim(frame_w_r);
  assign fh = frame_dim(frame_h_r);

  // input register
  logic                s0_vld_r;
  logic signed [C-1:0] s0_x_r, s0_y_r, s0_xl_r, s0_yl_r;
  logic signed [C-1:0] s0_u_r, s0_v_r, s0_ul_r, s0_vl_r;
  logic                s0_hid_r;

  assign in_chan.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) s0_vld_r <= 1'b0;
    else if (en) s0_vld_r <= in_chan.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_x_r   <= in_chan.dest_x;
      s0_y_r   <= in_chan.dest_y;
      s0_xl_r  <= in_chan.dest_width;
      s0_yl_r  <= in_chan.dest_height;
      s0_u_r   <= in_chan.tex_u;
      s0_v_r   <= in_chan.tex_v;
      s0_ul_r  <= in_chan.tex_width;
      s0_vl_r  <= in_chan.tex_height;
      s0_hid_r <= in_chan.hidden;
    end
  end

  // reject test
  logic signed [EW-1:0] x_e, y_e, xl_e, yl_e, fw_e, fh_e;
  logic signed [EW-1:0] xr_e, yb_e;
  logic                 reject;

  assign x_e  = EW'(s0_x_r);
  assign y_e  = EW'(s0_y_r);
  assign xl_e = EW'(s0_xl_r);
  assign yl_e = EW'(s0_yl_r);
  assign fw_e = $signed(EW'({1'b0, fw}));
  assign fh_e = $signed(EW'({1'b0, fh}));
  assign xr_e = x_e + xl_e;
  assign yb_e = y_e + yl_e;
  assign reject = s0_hid_r || (xl_e <= 0) || (yl_e <= 0) || (xr_e <= 0) || (yb_e <= 0) ||
                  (x_e >= fw_e) || (y_e >= fh_e);

  logic                s1_vld_r;
  logic                s1_vis_r;
  logic signed [C-1:0] s1_x_r, s1_y_r, s1_xl_r, s1_yl_r;
  logic signed [C-1:0] s1_u_r, s1_v_r, s1_ul_r, s1_vl_r;
  frame_t              s1_fw_r, s1_fh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else if (en) s1_vld_r <= s0_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_vis_r <= !reject;
      s1_x_r   <= s0_x_r;
      s1_y_r   <= s0_y_r;
      s1_xl_r  <= s0_xl_r;
      s1_yl_r  <= s0_yl_r;
      s1_u_r   <= s0_u_r;
      s1_v_r   <= s0_v_r;
      s1_ul_r  <= s0_ul_r;
      s1_vl_r  <= s0_vl_r;
      s1_fw_r  <= fw;
      s1_fh_r  <= fh;
    end
  end

  // the two axes run side by side with identical latency
  logic                xa_vld, ya_vld;
  logic signed [C-1:0] xa_pos, xa_len, ya_pos, ya_len;
  logic signed [C:0]   xa_t0, xa_tl, ya_t0, ya_tl;
  logic [0:0]          xa_vis, ya_vis;

  grc_axis #(.C(C), .OSIDE_W(1)) u_axis_x (
    .clk, .rst_n, .en,
    .in_vld(s1_vld_r), .in_pos(s1_x_r), .in_len(s1_xl_r), .in_t0(s1_u_r),
    .in_tl(s1_ul_r), .in_fd(s1_fw_r), .in_side(s1_vis_r),
    .out_vld(xa_vld), .out_pos(xa_pos), .out_len(xa_len), .out_t0(xa_t0),
    .out_tl(xa_tl), .out_side(xa_vis)
  );

  grc_axis #(.C(C), .OSIDE_W(1)) u_axis_y (
    .clk, .rst_n, .en,
    .in_vld(s1_vld_r), .in_pos(s1_y_r), .in_len(s1_yl_r), .in_t0(s1_v_r),
    .in_tl(s1_vl_r), .in_fd(s1_fh_r), .in_side(s1_vis_r),
    .out_vld(ya_vld), .out_pos(ya_pos), .out_len(ya_len), .out_t0(ya_t0),
    .out_tl(ya_tl), .out_side(ya_vis)
  );

  function automatic logic [OUT_LEN_W-1:0] sat_u(input logic signed [EW-1:0] v,
                                                 input int unsigned hi);
    logic [OUT_LEN_W-1:0] r;
    if (v < 0) r = '0;
    else if (v > $signed(EW'(hi))) r = OUT_LEN_W'(hi);
    else r = v[OUT_LEN_W-1:0];
    return r;
  endfunction

  function automatic logic signed [C-1:0] sat_c(input logic signed [C:0] v);
    logic signed [C-1:0] r;
    if (v > $signed({2'b00, {(C-1){1'b1}}})) r = {1'b0, {(C-1){1'b1}}};
    else if (v < $signed({2'b11, {(C-1){1'b0}}})) r = {1'b1, {(C-1){1'b0}}};
    else r = v[C-1:0];
    return r;
  endfunction

  // output register
  logic                     o_vld_r;
  logic                     o_vis_r;
  logic [OUT_POS_W-1:0]     o_x_r, o_y_r;
  logic [OUT_LEN_W-1:0]     o_w_r, o_h_r;
  logic signed [C-1:0]      o_u_r, o_v_r, o_ul_r, o_vl_r;
  logic                     vis;
  logic [OUT_LEN_W-1:0]     sx, sy;

  assign en  = !o_vld_r || out_chan.ready;
  assign vis = xa_vis[0] && ya_vis[0];
  assign sx  = sat_u(EW'(xa_pos), POS_MAX);
  assign sy  = sat_u(EW'(ya_pos), POS_MAX);

  always_ff @(posedge clk) begin
    if (!rst_n) o_vld_r <= 1'b0;
    else if (en) o_vld_r <= xa_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_vis_r <= vis;
      o_x_r   <= vis ? sx[OUT_POS_W-1:0] : '0;
      o_y_r   <= vis ? sy[OUT_POS_W-1:0] : '0;
      o_w_r   <= vis ? sat_u(EW'(xa_len), LEN_MAX) : '0;
      o_h_r   <= vis ? sat_u(EW'(ya_len), LEN_MAX) : '0;
      o_u_r   <= vis ? sat_c(xa_t0) : '0;
      o_v_r   <= vis ? sat_c(ya_t0) : '0;
      o_ul_r  <= vis ? sat_c(xa_tl) : '0;
      o_vl_r  <= vis ? sat_c(ya_tl) : '0;
    end
  end

  assign out_chan.valid          = o_vld_r;
  assign out_chan.visible        = o_vis_r;
  assign out_chan.out_x          = o_x_r;
  assign out_chan.out_y          = o_y_r;
  assign out_chan.out_width      = o_w_r;
  assign out_chan.out_height     = o_h_r;
  assign out_chan.out_u          = o_u_r;
  assign out_chan.out_v          = o_v_r;
  assign out_chan.out_tex_width  = o_ul_r;
  assign out_chan.out_tex_height = o_vl_r;

  `GRC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !o_vld_r, "output valid after reset")
  `GRC_ASSERT(a_axes_aligned, xa_vld == ya_vld, "axis pipelines out of step")
  `GRC_ASSERT(a_axis_vis_agree, xa_vld |-> (xa_vis == ya_vis), "axes disagree on visibility")
  `GRC_ASSERT(a_rejected_zero, (o_vld_r && !o_vis_r) |-> (o_w_r == '0 && o_h_r == '0 && o_u_r == '0),
    "rejected result not cleared")
  `GRC_ASSERT(a_inside_frame, (o_vld_r && o_vis_r) |->
    ((o_w_r != '0) && ({2'b00, o_x_r} + {1'b0, o_w_r} <= {1'b0, fw})),
    "visible rectangle leaves the frame")

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import grc_pkg::*;

  localparam int CB = 16;
  localparam int LATENCY = 2 * CB + 9;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct {
    logic signed [CB-1:0] dest_x, dest_y, dest_width, dest_height;
    logic signed [CB-1:0] tex_u, tex_v, tex_width, tex_height;
    logic                 hidden;
  } rect_t;

  typedef struct {
    logic                 visible;
    logic [13:0]          px, py;
    logic [14:0]          pw, ph;
    logic signed [CB-1:0] u, v, tw, th;
  } clip_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  cfg_index_t cfg_index;
  frame_t cfg_wdata;

  grc_in_if #(.COORD_BITS(CB)) in_chan ();
  grc_out_if #(.COORD_BITS(CB)) out_chan ();

  glyph_rectangle_clip #(.COORD_BITS(CB)) u_dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  frame_t model_fw, model_fh;
  clip_t pending_clips[$];
  int errors;
  int rects_sent;
  int clips_seen;
  int visible_seen;
  bit in_idle_en;
  bit out_idle_en;
  int hold_left;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint eff_dim(frame_t r);
    if (r == 0) return 1;
    if (r > FRAME_MAX) return FRAME_MAX;
    return longint'(r);
  endfunction

  // (a*b)/c truncated toward zero, exact
  function automatic longint cut(longint a, longint b, longint c);
    return a * (b / c) + (a * (b % c)) / c;
  endfunction

  function automatic longint clamp(longint val, longint lo, longint hi);
    if (val < lo) return lo;
    if (val > hi) return hi;
    return val;
  endfunction

  function automatic clip_t clip_rect(rect_t r);
    longint x, y, xl, yl, u, v, ul, vl, fw, fh, c;
    clip_t o;
    x = r.dest_x; y = r.dest_y; xl = r.dest_width; yl = r.dest_height;
    u = r.tex_u; v = r.tex_v; ul = r.tex_width; vl = r.tex_height;
    fw = eff_dim(model_fw);
    fh = eff_dim(model_fh);
    o = '{default: '0};
    if (r.hidden || xl <= 0 || yl <= 0 || x + xl <= 0 || y + yl <= 0 || x >= fw || y >= fh)
      return o;
    if (x < 0) begin
      c = cut(x, ul, xl);
      u -= c; ul += c; xl += x; x = 0;
    end
    if (y < 0) begin
      c = cut(y, vl, yl);
      v -= c; vl += c; yl += y; y = 0;
    end
    if (xl > fw - x) begin
      ul += cut(fw - x - xl, ul, xl);
      xl = fw - x;
    end
    if (yl > fh - y) begin
      vl += cut(fh - y - yl, vl, yl);
      yl = fh - y;
    end
    o.visible = 1'b1;
    o.px = 14'(clamp(x, 0, POS_MAX));
    o.py = 14'(clamp(y, 0, POS_MAX));
    o.pw = 15'(clamp(xl, 0, LEN_MAX));
    o.ph = 15'(clamp(yl, 0, LEN_MAX));
    o.u  = 16'(clamp(u, -32768, 32767));
    o.v  = 16'(clamp(v, -32768, 32767));
    o.tw = 16'(clamp(ul, -32768, 32767));
    o.th = 16'(clamp(vl, -32768, 32767));
    return o;
  endfunction

  // drive one rectangle; returns at the edge where it transfers
  task automatic send_rect(rect_t r);
    logic rdy;
    if (in_idle_en && $urandom_range(0, 99) < 21) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.dest_x      <= r.dest_x;
    in_chan.dest_y      <= r.dest_y;
    in_chan.dest_width  <= r.dest_width;
    in_chan.dest_height <= r.dest_height;
    in_chan.tex_u       <= r.tex_u;
    in_chan.tex_v       <= r.tex_v;
    in_chan.tex_width   <= r.tex_width;
    in_chan.tex_height  <= r.tex_height;
    in_chan.hidden      <= r.hidden;
    do begin
      @(negedge clk);
      rdy = in_chan.ready;
      @(posedge clk);
    end while (!rdy);
    pending_clips.push_back(clip_rect(r));
    rects_sent++;
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    while (pending_clips.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_frame(cfg_index_t idx, frame_t val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_FRAME_WIDTH) model_fw = val;
    else model_fh = val;
  endtask

  function automatic rect_t mk(int x, int y, int w, int h, int u, int v, int tw, int th,
                               bit hid);
    rect_t r;
    r.dest_x = 16'(x); r.dest_y = 16'(y); r.dest_width = 16'(w); r.dest_height = 16'(h);
    r.tex_u = 16'(u); r.tex_v = 16'(v); r.tex_width = 16'(tw); r.tex_height = 16'(th);
    r.hidden = hid;
    return r;
  endfunction

  function automatic rect_t noise_rect();
    rect_t r;
    r.dest_x = 16'($urandom); r.dest_y = 16'($urandom);
    r.dest_width = 16'($urandom); r.dest_height = 16'($urandom);
    r.tex_u = 16'($urandom); r.tex_v = 16'($urandom);
    r.tex_width = 16'($urandom); r.tex_height = 16'($urandom);
    r.hidden = 1'($urandom);
    return r;
  endfunction

  // mostly rectangles near the frame so that each clipping edge is hit
  function automatic rect_t near_rect();
    int fw, fh;
    rect_t r;
    fw = int'(eff_dim(model_fw));
    fh = int'(eff_dim(model_fh));
    r = noise_rect();
    r.dest_x = 16'(int'($urandom_range(0, 2 * fw + 64)) - fw / 2 - 32);
    r.dest_y = 16'(int'($urandom_range(0, 2 * fh + 64)) - fh / 2 - 32);
    r.dest_width = 16'($urandom_range(1, fw + 64));
    r.dest_height = 16'($urandom_range(1, fh + 64));
    if ($urandom_range(0, 3) != 0) begin
      r.tex_width = 16'(int'($urandom_range(0, 1024)) - 256);
      r.tex_height = 16'(int'($urandom_range(0, 1024)) - 256);
    end
    r.hidden = ($urandom_range(0, 15) == 0);
    return r;
  endfunction

  task automatic test_directed();
    send_rect(mk(10, 10, 20, 20, 0, 0, 64, 64, 1));
    send_rect(mk(10, 10, 0, 20, 0, 0, 64, 64, 0));
    send_rect(mk(10, 10, 20, -5, 0, 0, 64, 64, 0));
    send_rect(mk(10, 10, -32768, -32768, 0, 0, 64, 64, 0));
    send_rect(mk(-20, 10, 20, 20, 0, 0, 64, 64, 0));
    send_rect(mk(10, -20, 20, 20, 0, 0, 64, 64, 0));
    send_rect(mk(640, 10, 20, 20, 0, 0, 64, 64, 0));
    send_rect(mk(10, 480, 20, 20, 0, 0, 64, 64, 0));
    send_rect(mk(0, 0, 640, 480, 5, 7, 640, 480, 0));
    send_rect(mk(-7, 3, 30, 30, 100, 200, -33, 47, 0));
    send_rect(mk(3, -9, 30, 30, -100, 20, 33, -47, 0));
    send_rect(mk(630, 400, 30, 100, 1, 2, 99, 77, 0));
    send_rect(mk(-100, -100, 1000, 1000, 32767, -32768, 32767, -32768, 0));
    send_rect(mk(-32768, -32768, 32767, 32767, -32768, 32767, -32768, 32767, 0));
    send_rect(mk(32767, 32767, 32767, 32767, 0, 0, 1, 1, 0));
    send_rect(mk(639, 479, 1, 1, -32768, -32768, -32768, -32768, 0));
    send_rect(mk(-1, -1, 2, 2, 32767, 32767, 32767, 32767, 0));
    send_rect(mk(-32767, 0, 32767, 5, -32768, 0, -32768, 3, 0));
    send_rect(mk(0, 0, 32767, 32767, 32767, 32767, 32767, 32767, 0));
    drain();
  endtask

  task automatic test_frame_extremes();
    rect_t r;
    write_frame(CFG_FRAME_WIDTH, 15'd0);
    write_frame(CFG_FRAME_HEIGHT, 15'd0);
    send_rect(mk(0, 0, 5, 5, 0, 0, 50, 50, 0));
    send_rect(mk(-3, -3, 10, 10, 3, 3, 100, 100, 0));
    for (int i = 0; i < 20; i++) send_rect(near_rect());
    write_frame(CFG_FRAME_WIDTH, 15'd16384);
    write_frame(CFG_FRAME_HEIGHT, 15'd16384);
    send_rect(mk(-5, -5, 32767, 32767, -32768, 32767, 32767, -32768, 0));
    send_rect(mk(16383, 16383, 5, 5, 0, 0, 9, 9, 0));
    for (int i = 0; i < 40; i++) send_rect(near_rect());
    write_frame(CFG_FRAME_WIDTH, 15'h7fff);
    write_frame(CFG_FRAME_HEIGHT, 15'd1);
    for (int i = 0; i < 40; i++) send_rect(near_rect());
    write_frame(CFG_FRAME_WIDTH, 15'd1);
    write_frame(CFG_FRAME_HEIGHT, 15'h7fff);
    for (int i = 0; i < 40; i++) send_rect(near_rect());
    write_frame(CFG_FRAME_WIDTH, 15'h4001);
    write_frame(CFG_FRAME_HEIGHT, 15'h2aaa);
    r = mk(-10, -10, 30000, 30000, 1, 1, 1000, 1000, 0);
    send_rect(r);
    for (int i = 0; i < 30; i++) send_rect(near_rect());
  endtask

  task automatic test_random_frames();
    for (int p = 0; p < 6; p++) begin
      write_frame(CFG_FRAME_WIDTH, frame_t'($urandom_range(1, 2000)));
      write_frame(CFG_FRAME_HEIGHT, frame_t'($urandom_range(1, 2000)));
      for (int i = 0; i < 50; i++)
        send_rect(($urandom_range(0, 99) < 75) ? near_rect() : noise_rect());
    end
  endtask

  task automatic test_no_idling();
    in_idle_en = 1'b0;
    out_idle_en = 1'b0;
    for (int i = 0; i < 60; i++) send_rect(near_rect());
    in_idle_en = 1'b1;
    out_idle_en = 1'b1;
  endtask

  task automatic test_backpressure();
    hold_left = 300;
    for (int i = 0; i < 60; i++) send_rect(near_rect());
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= !(out_idle_en && $urandom_range(0, 99) < 21);
    end
  end

  task automatic check_field(string name, longint exp_val, longint act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, exp_val,
               act_val);
      errors++;
    end
  endtask

  always @(negedge clk) begin
    clip_t e;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      clips_seen++;
      if (pending_clips.size() == 0) begin
        $display("%0t: result with nothing expected", $realtime);
        errors++;
      end else begin
        e = pending_clips.pop_front();
        if (e.visible) visible_seen++;
        check_field("visible", e.visible, out_chan.visible);
        check_field("out_x", e.px, out_chan.out_x);
        check_field("out_y", e.py, out_chan.out_y);
        check_field("out_width", e.pw, out_chan.out_width);
        check_field("out_height", e.ph, out_chan.out_height);
        check_field("out_u", e.u, out_chan.out_u);
        check_field("out_v", e.v, out_chan.out_v);
        check_field("out_tex_width", e.tw, out_chan.out_tex_width);
        check_field("out_tex_height", e.th, out_chan.out_tex_height);
      end
    end
  end

  // ends the run if nothing transfers for too long
  always @(negedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $realtime);
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    errors = 0;
    rects_sent = 0;
    clips_seen = 0;
    visible_seen = 0;
    hold_left = 0;
    quiet_cycles = 0;
    in_idle_en = 1'b1;
    out_idle_en = 1'b1;
    model_fw = FRAME_W_RST;
    model_fh = FRAME_H_RST;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_wdata <= '0;
    in_chan.valid <= 1'b0;
    in_chan.dest_x <= '0;
    in_chan.dest_y <= '0;
    in_chan.dest_width <= '0;
    in_chan.dest_height <= '0;
    in_chan.tex_u <= '0;
    in_chan.tex_v <= '0;
    in_chan.tex_width <= '0;
    in_chan.tex_height <= '0;
    in_chan.hidden <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_no_idling();
    test_backpressure();
    test_frame_extremes();
    test_random_frames();
    drain();
    $display("sent %0d rectangles, %0d results checked, %0d visible", rects_sent,
             clips_seen, visible_seen);
    $display("covered reject cases, edge clipping, frame extremes, stalls and idling");
    if (errors == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule
